>>> sv/prefix_code_bit_decoder_assert.svh
// Assertion macros used by the bound checker module pcbd_checker.
`ifndef PREFIX_CODE_BIT_DECODER_ASSERT_SVH
`define PREFIX_CODE_BIT_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PCBD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/pcbd_pkg.sv
package pcbd_pkg;

  // Table geometry
  localparam int NUM_ENTRIES      = 257;
  localparam int SYM_W            = 9;
  localparam int LEN_W            = 5;
  localparam int IN_CODE_W        = 16;
  localparam int BYTE_W           = 8;
  localparam int STATUS_W         = 2;
  localparam int CMP_LW           = 6;   // common width for length compares
  localparam int DEF_MAX_CODE_LEN = 16;

  localparam logic [SYM_W-1:0] END_SYMBOL = 9'd256;

  // Input item kinds
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_SYMBOL = 2'd0;
  localparam logic [STATUS_W-1:0] ST_END    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOCODE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNUSED = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_write;   // zero one table entry during the clearing pass
    logic load;        // write an entry, reset accumulator and end flag
    logic start_byte;  // latch a data byte
    logic shift;       // move one bit into the accumulator
    logic scan_start;  // rewind table scan
    logic scan_run;    // read one entry, advance scan
    logic capture;     // record a result, clear accumulator
    logic commit;      // pending -> output (not last), new result -> pending
    logic flush;       // pending -> output as last beat
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic hit;
    logic scan_done;
    logic acc_full;
    logic bits_left;
    logic end_reached;
    logic pend_valid;
    logic out_free;
  } stat_t;

endpackage

>>> sv/pcbd_dpath.sv
module pcbd_dpath
  import pcbd_pkg::*;
#(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output stat_t                stat,
  input  logic [SYM_W-1:0]     entry_symbol,
  input  logic [IN_CODE_W-1:0] entry_code,
  input  logic [LEN_W-1:0]     entry_length,
  input  logic [BYTE_W-1:0]    data_byte,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [STATUS_W-1:0]  out_status,
  output logic [BYTE_W-1:0]    out_symbol,
  output logic                 out_last
);

  localparam int CW  = MAX_CODE_LEN;
  localparam int ALW = $clog2(MAX_CODE_LEN + 1);
  localparam int EW  = LEN_W + CW;

  // Code table: {length, code}
  logic [EW-1:0]       mem [NUM_ENTRIES];
  logic [SYM_W-1:0]    addr;
  logic [EW-1:0]       rd_q;
  logic [SYM_W-1:0]    rd_sym;
  logic                rd_v;

  logic                mem_we;
  logic [SYM_W-1:0]    mem_waddr;
  logic [EW-1:0]       mem_wdata;
  logic [31:0]         code_mask;
  logic [31:0]         code_masked;

  // Decode state
  logic [CW-1:0]       acc;
  logic [ALW-1:0]      acc_len;
  logic                end_r;
  logic [BYTE_W-1:0]   sh;
  logic [3:0]          bits_rem;

  // Result staging
  logic [STATUS_W-1:0] found_status;
  logic [BYTE_W-1:0]   found_sym;
  logic                pend_v;
  logic [STATUS_W-1:0] pend_status;
  logic [BYTE_W-1:0]   pend_sym;

  logic [LEN_W-1:0]    rd_len;
  logic [CW-1:0]       rd_code;
  logic                hit;

  // Table write port: clearing pass or entry load
  always_comb begin
    code_mask   = (32'd1 << entry_length) - 32'd1;
    code_masked = {{(32-IN_CODE_W){1'b0}}, entry_code} & code_mask;
    mem_we      = cmd.clr_write || (cmd.load && (entry_symbol <= END_SYMBOL));
    mem_waddr   = cmd.clr_write ? addr : entry_symbol;
    mem_wdata   = cmd.clr_write ? '0 : {entry_length, CW'(code_masked)};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.scan_run) begin
      rd_q   <= mem[addr];
      rd_sym <= addr;
    end
  end

  // Scan / clear address and read-valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
      rd_v <= 1'b0;
    end else begin
      rd_v <= cmd.scan_run;
      if (cmd.clr_write) begin
        addr <= addr + SYM_W'(1);
      end else if (cmd.scan_start) begin
        addr <= '0;
      end else if (cmd.scan_run && addr != END_SYMBOL) begin
        addr <= addr + SYM_W'(1);
      end
    end
  end

  // Compare the entry read last cycle against the accumulator
  always_comb begin
    rd_len  = rd_q[EW-1 -: LEN_W];
    rd_code = rd_q[CW-1:0];
    hit     = rd_v && (rd_len != '0) && (CMP_LW'(rd_len) == CMP_LW'(acc_len)) &&
              (rd_code == acc);
  end

  // Accumulator, bit source and end flag
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      acc_len  <= '0;
      end_r    <= 1'b0;
      bits_rem <= '0;
    end else begin
      if (cmd.load) begin
        acc     <= '0;
        acc_len <= '0;
        end_r   <= 1'b0;
      end else if (cmd.capture) begin
        acc     <= '0;
        acc_len <= '0;
        if (hit && rd_sym == END_SYMBOL) begin
          end_r <= 1'b1;
        end
      end else if (cmd.shift) begin
        acc     <= {acc[CW-2:0], sh[BYTE_W-1]};
        acc_len <= acc_len + ALW'(1);
      end
      if (cmd.start_byte) begin
        bits_rem <= 4'd8;
      end else if (cmd.shift) begin
        bits_rem <= bits_rem - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_byte) begin
      sh <= data_byte;
    end else if (cmd.shift) begin
      sh <= {sh[BYTE_W-2:0], 1'b0};
    end
  end

  // Result capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      if (hit && rd_sym == END_SYMBOL) begin
        found_status <= ST_END;
        found_sym    <= '0;
      end else if (hit) begin
        found_status <= ST_SYMBOL;
        found_sym    <= rd_sym[BYTE_W-1:0];
      end else begin
        found_status <= ST_NOCODE;
        found_sym    <= '0;
      end
    end
  end

  // Pending result: held until we know whether it is the last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else if (cmd.commit) begin
      pend_v <= 1'b1;
    end else if (cmd.flush) begin
      pend_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pend_status <= found_status;
      pend_sym    <= found_sym;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.commit && pend_v) || cmd.flush) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.commit && pend_v) || cmd.flush) begin
      out_status <= pend_status;
      out_symbol <= pend_sym;
      out_last   <= cmd.flush;
    end
  end

  always_comb begin
    stat.clear_last  = (addr == END_SYMBOL);
    stat.hit         = hit;
    stat.scan_done   = rd_v && (rd_sym == END_SYMBOL);
    stat.acc_full    = (acc_len >= ALW'(MAX_CODE_LEN));
    stat.bits_left   = (bits_rem != '0);
    stat.end_reached = end_r;
    stat.pend_valid  = pend_v;
    stat.out_free    = !out_valid || out_ready;
  end

endmodule

>>> sv/pcbd_ctrl.sv
module pcbd_ctrl
  import pcbd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_mode,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_FLUSH  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      // Zero every table entry after reset
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == MODE_LOAD) begin
            cmd.load = 1'b1;
          end else if (!stat.end_reached) begin
            cmd.start_byte = 1'b1;
            state_next     = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift      = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = S_SCAN;
      end
      // Walk the table in symbol order; first hit wins
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.hit) begin
          cmd.capture = 1'b1;
          state_next  = S_COMMIT;
        end else if (stat.scan_done) begin
          if (stat.acc_full) begin
            cmd.capture = 1'b1;
            state_next  = S_COMMIT;
          end else if (stat.bits_left) begin
            state_next = S_SHIFT;
          end else begin
            state_next = S_FLUSH;
          end
        end
      end
      S_COMMIT: begin
        if (!stat.pend_valid || stat.out_free) begin
          cmd.commit = 1'b1;
          if (stat.end_reached || !stat.bits_left) begin
            state_next = S_FLUSH;
          end else begin
            state_next = S_SHIFT;
          end
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/prefix_code_bit_decoder.sv
// Bit-serial prefix-code decoder with a loadable 257-entry code table (byte
// symbols 0..255 plus the end marker 256). A load beat (s_tuser 0) writes one
// entry unless its symbol is past 256; a decode beat (s_tuser 1) feeds eight
// code bits, most significant first. Each bit costs a shift step plus a walk
// of the table memory, one entry per cycle in symbol order, stopping at the
// first match or after the last entry. A data byte therefore goes through an
// accept step, the shifting and walking, a commit step per result and a flush
// step, plus any wait on m_tready. Up to eight results leave per decode beat,
// tlast on the final one. After reset the block zeroes every table entry
// before it raises s_tready. After the end marker decodes, decode beats are
// dropped until the next load beat.
module prefix_code_bit_decoder
  import pcbd_pkg::*;
#(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // entry_symbol[8:0], entry_code[24:9], entry_length[29:25],
  // data_byte[37:30], zero fill
  input  logic [39:0] s_tdata,
  // mode[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // symbol[7:0]
  output logic [7:0]  m_tdata,
  // status[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  cmd_t                cmd;
  stat_t               stat;

  pcbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_mode  (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcbd_dpath #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .entry_symbol (s_tdata[8:0]),
    .entry_code   (s_tdata[24:9]),
    .entry_length (s_tdata[29:25]),
    .data_byte    (s_tdata[37:30]),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_status   (m_tuser),
    .out_symbol   (m_tdata),
    .out_last     (m_tlast)
  );

endmodule

>>> sv/pcbd_checker.sv
`include "prefix_code_bit_decoder_assert.svh"

module pcbd_checker
  import pcbd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);

  // Stalled output beat stays offered
  `PCBD_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "beat dropped")

  // Stalled output beat keeps its contents
  `PCBD_ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable({m_tdata, m_tuser, m_tlast}), "beat changed")

  // Status never takes the spare code
  `PCBD_ASSERT_IMPL(a_status_code, clk, rst, m_tvalid, m_tuser != ST_UNUSED, "bad status")

  // Non-symbol results carry a zero symbol
  `PCBD_ASSERT_IMPL(a_sym_zero, clk, rst, m_tvalid && (m_tuser != ST_SYMBOL), m_tdata == 8'd0, "symbol not zero")

  // End marker always closes the beat group
  `PCBD_ASSERT_IMPL(a_end_last, clk, rst, m_tvalid && (m_tuser == ST_END), m_tlast, "end without tlast")

endmodule

bind prefix_code_bit_decoder pcbd_checker u_pcbd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

>>> dv/prefix_code_bit_decoder_checker.sv
// Watches both stream channels, predicts the decoded results of every accepted
// input beat and compares them with the beats leaving the block.
module prefix_code_bit_decoder_checker
  import pcbd_pkg::*;
#(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  output int          outstanding,  // results predicted but not yet seen
  output int          live_beats,   // accepted beats that the block acts on
  output int          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   symbol;
    logic                last;
  } dec_result_t;

  dec_result_t decoded_q[$];

  // Shadow copy of the code table and the bit accumulator
  logic [IN_CODE_W-1:0] tab_code [NUM_ENTRIES];
  logic [LEN_W-1:0]     tab_len  [NUM_ENTRIES];
  logic [31:0]          acc_bits;
  int                   acc_len;
  bit                   at_end;
  int                   n_bad;
  int                   n_live;

  // Lowest valid entry equal to the accumulator, -1 if none
  function automatic int lowest_match();
    for (int s = 0; s < NUM_ENTRIES; s++) begin
      if (tab_len[s] != 0 && int'(tab_len[s]) == acc_len &&
          {16'b0, tab_code[s]} == acc_bits)
        return s;
    end
    return -1;
  endfunction

  function automatic void add_result(input logic [STATUS_W-1:0] status,
                                     input logic [BYTE_W-1:0] symbol);
    dec_result_t r;
    r.status = status;
    r.symbol = symbol;
    r.last   = 1'b0;
    decoded_q.push_back(r);
    acc_bits = '0;
    acc_len  = 0;
  endfunction

  // Table write or bit-serial decode of one input beat
  function automatic void predict_beat(input logic mode, input logic [39:0] beat);
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] len;
    logic [31:0]      mask;
    int               hit;
    int               first_new;
    dec_result_t      r;
    sym = beat[8:0];
    len = beat[29:25];
    if (mode == MODE_LOAD) begin
      // out-of-range symbols write nothing but still reset the decoder
      if (sym < NUM_ENTRIES) begin
        mask = (32'd1 << len) - 32'd1;
        tab_code[sym] = beat[24:9] & mask[15:0];
        tab_len[sym]  = len;
      end
      acc_bits = '0;
      acc_len  = 0;
      at_end   = 1'b0;
      n_live++;
    end else if (!at_end) begin
      n_live++;
      first_new = decoded_q.size();
      for (int j = 7; j >= 0; j--) begin
        acc_bits = {acc_bits[30:0], beat[30+j]};
        acc_len++;
        hit = lowest_match();
        if (hit == int'(END_SYMBOL)) begin
          // rest of the byte is dropped
          add_result(ST_END, '0);
          at_end = 1'b1;
          break;
        end else if (hit >= 0) begin
          add_result(ST_SYMBOL, hit[7:0]);
        end else if (acc_len >= MAX_CODE_LEN) begin
          add_result(ST_NOCODE, '0);
        end
      end
      if (decoded_q.size() > first_new) begin
        r = decoded_q.pop_back();
        r.last = 1'b1;
        decoded_q.push_back(r);
      end
    end
  endfunction

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin
    dec_result_t got;
    dec_result_t want;
    if (rst) begin
      for (int s = 0; s < NUM_ENTRIES; s++) begin
        tab_code[s] = '0;
        tab_len[s]  = '0;
      end
      acc_bits = '0;
      acc_len  = 0;
      at_end   = 1'b0;
      decoded_q.delete();
    end else begin
      if (s_tvalid && s_tready)
        predict_beat(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        got.status = m_tuser;
        got.symbol = m_tdata;
        got.last   = m_tlast;
        if (decoded_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: unexpected result beat status=%0d symbol=%0d last=%0b",
                     $realtime, got.status, got.symbol, got.last);
        end else begin
          want = decoded_q.pop_front();
          if (got.status !== want.status || got.symbol !== want.symbol ||
              got.last !== want.last) begin
            n_bad++;
            if (n_bad <= 10)
              $display("%0t: mismatch exp st=%0d sym=%0d last=%0b got st=%0d sym=%0d last=%0b",
                       $realtime, want.status, want.symbol, want.last,
                       got.status, got.symbol, got.last);
          end
        end
      end
    end
    outstanding <= decoded_q.size();
    live_beats  <= n_live;
    mismatches  <= n_bad;
  end

endmodule

>>> dv/prefix_code_bit_decoder_tb.sv
// Stimulus and verdict for the prefix-code decoder; checking lives in the
// checker module instantiated beside the block.
module prefix_code_bit_decoder_tb
  import pcbd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STIM_BEATS   = 500;
  localparam int DRAIN_CYCLES = 3000;  // worst byte is 8 full table walks

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int outstanding;
  int live_beats;
  int mismatches;
  int burst_left = 0;
  int rdy_left = 0;
  int rdy_style = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  prefix_code_bit_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  prefix_code_bit_decoder_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .outstanding (outstanding),
    .live_beats  (live_beats),
    .mismatches  (mismatches)
  );

  // Result side: stall styles held for random stretches
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_style = $urandom_range(0, 3);
      rdy_left  = $urandom_range(1, 40);
    end
    rdy_left--;
    case (rdy_style)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // One input beat; bursts of random length with idle gaps in between
  task automatic send_item(input logic mode, input logic [SYM_W-1:0] sym,
                           input logic [IN_CODE_W-1:0] code,
                           input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] data);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b0, data, len, code, sym};
    s_tuser  <= mode;
    do @(posedge clk); while (!s_tready);
  endtask

  // Ignored fields carry random values
  task automatic load_entry(input logic [SYM_W-1:0] sym, input logic [IN_CODE_W-1:0] code,
                            input logic [LEN_W-1:0] len);
    send_item(MODE_LOAD, sym, code, len, BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] data);
    send_item(MODE_DECODE, SYM_W'($urandom_range(0, 511)),
              IN_CODE_W'($urandom_range(0, 65535)), LEN_W'($urandom_range(0, 31)), data);
  endtask

  initial begin : stimulus
    logic [IN_CODE_W-1:0] leaf_code [64];
    int                   leaf_len  [64];
    bit                   in_use [NUM_ENTRIES];
    bit                   taken  [NUM_ENTRIES];
    logic [IN_CODE_W-1:0] code;
    logic [SYM_W-1:0]     sym;
    int n_leaves, target, depth_cap, tries, pick, end_leaf, drop_leaf, n_bytes;
    bit first_pause;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty table: one byte without result, then the no-code case at 16 bits
    decode_byte(8'hFF);
    decode_byte(8'h00);
    // "0" -> 0, "10" -> 255 (upper junk dropped), "11" -> end marker
    load_entry(9'd0, 16'h0000, 5'd1);
    load_entry(9'd255, 16'hFFFE, 5'd2);
    load_entry(END_SYMBOL, 16'h0003, 5'd2);
    // duplicate of symbol 0's code: lower symbol must win
    load_entry(9'd1, 16'hFFFE, 5'd1);
    // too long to ever match, and a symbol past the table
    load_entry(9'd2, 16'hFFFF, 5'd31);
    load_entry(9'd511, 16'h1234, 5'd4);
    decode_byte(8'h00);             // eight results
    decode_byte(8'h90);
    decode_byte(8'h6A);             // end marker mid-byte, tail dropped
    decode_byte(8'h00);             // ignored after end
    // a load clears the end flag; unused entry and a full-length code
    load_entry(END_SYMBOL, 16'h0003, 5'd0);
    load_entry(9'd3, 16'hFFFF, 5'd16);
    load_entry(9'd4, 16'h0000, 5'd0);
    decode_byte(8'hFF);
    decode_byte(8'hFF);
    decode_byte(8'hC0);

    foreach (in_use[i]) in_use[i] = (i <= 4 || i >= 255);
    first_pause = 1'b1;

    // Random sessions: fresh prefix code, then coded bytes with some noise
    while (live_beats < STIM_BEATS) begin
      // retire the previous table, now and then leave it stale
      if ($urandom_range(0, 7) != 0) begin
        for (int s = 0; s < NUM_ENTRIES; s++) begin
          if (in_use[s]) begin
            load_entry(s[SYM_W-1:0], IN_CODE_W'($urandom_range(0, 65535)), 5'd0);
            in_use[s] = 1'b0;
          end
        end
      end

      // grow a random code tree by splitting leaves
      n_leaves     = 1;
      leaf_code[0] = '0;
      leaf_len[0]  = 0;
      target    = $urandom_range(2, ($urandom_range(0, 7) == 0) ? 48 : 16);
      depth_cap = ($urandom_range(0, 5) == 0) ? 16 : $urandom_range(3, 8);
      tries     = 0;
      while (n_leaves < target && tries < 400) begin
        tries++;
        pick = $urandom_range(0, n_leaves - 1);
        if (leaf_len[pick] < depth_cap) begin
          leaf_code[n_leaves] = {leaf_code[pick][14:0], 1'b1};
          leaf_len[n_leaves]  = leaf_len[pick] + 1;
          leaf_code[pick]     = {leaf_code[pick][14:0], 1'b0};
          leaf_len[pick]++;
          n_leaves++;
        end
      end

      // symbols per leaf; maybe an end marker, maybe a hole in the code
      end_leaf  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, n_leaves - 1)) : -1;
      drop_leaf = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, n_leaves - 1)) : -1;
      foreach (taken[i]) taken[i] = 1'b0;
      for (int i = 0; i < n_leaves; i++) begin
        if (i == end_leaf) begin
          sym = END_SYMBOL;
        end else begin
          do sym = SYM_W'($urandom_range(0, 255)); while (taken[sym]);
        end
        taken[sym] = 1'b1;
        if (i != drop_leaf) begin
          code = leaf_code[i];
          if ($urandom_range(0, 3) == 0)
            code = code | (16'($urandom_range(0, 65535)) << leaf_len[i]);
          load_entry(sym, code, LEN_W'(leaf_len[i]));
          in_use[sym] = 1'b1;
        end
      end

      // coded bytes, with the odd stray load in between
      n_bytes = $urandom_range(2, 24);
      for (int b = 0; b < n_bytes; b++) begin
        if ($urandom_range(0, 11) == 0) begin
          sym = SYM_W'($urandom_range(0, 511));
          load_entry(sym, IN_CODE_W'($urandom_range(0, 65535)),
                     LEN_W'($urandom_range(0, 31)));
          if (sym < NUM_ENTRIES)
            in_use[sym] = 1'b1;
        end else begin
          decode_byte(BYTE_W'($urandom_range(0, 255)));
        end
      end

      // hold off until the block has delivered everything
      if (first_pause || $urandom_range(0, 5) == 0) begin
        first_pause = 1'b0;
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
      end
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("prefix_code_bit_decoder regression: pass");
    else
      $display("prefix_code_bit_decoder regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #80_000_000;
    $display("prefix_code_bit_decoder regression: fail");
    $finish;
  end

endmodule
